/* rtl/bas_pkg.sv */
package bas_pkg;

  // Default number of words the stack can hold.
  localparam int unsigned DefaultDepth = 8;

  // Widths of the request and response fields.
  localparam int unsigned FuncWidth   = 4;
  localparam int unsigned PosWidth    = 3;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned IndexWidth  = 4;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned CountWidth  = 4;

  // Search result when no entry matches.
  localparam logic [IndexWidth-1:0] FoundNone = '1;

  typedef enum logic [FuncWidth-1:0] {
    FN_PUSH      = 4'd0,
    FN_POP       = 4'd1,
    FN_PEEK      = 4'd2,
    FN_UPDATE    = 4'd3,
    FN_SEARCH    = 4'd4,
    FN_INSERT    = 4'd5,
    FN_DEL_FIRST = 4'd6,
    FN_DEL_LAST  = 4'd7,
    FN_DEL_AT    = 4'd8
  } func_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BADPOS    = 3'd3,
    ST_NOTFOUND  = 3'd4
  } status_e;

endpackage

/* rtl/bas_in_if.sv */
interface bas_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic [2:0]         position;
  logic signed [31:0] value;

  modport source (output valid, func, position, value, input ready);
  modport sink (input valid, func, position, value, output ready);
endinterface

/* rtl/bas_out_if.sv */
interface bas_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_data;
  logic signed [3:0]  found_index;
  logic [2:0]         status;
  logic [3:0]         fill_count;
  logic               is_empty;
  logic               is_full;

  modport source (
    output valid, read_data, found_index, status, fill_count, is_empty, is_full,
    input ready
  );
  modport sink (
    input valid, read_data, found_index, status, fill_count, is_empty, is_full,
    output ready
  );
endinterface

/* rtl/bounded_array_stack_list.sv */
// Bounded stack of DEPTH signed 32-bit words with positional access. Each request
// on in_i names one operation (push, pop, peek, update, search, insert, delete
// first, delete last, delete at) and produces exactly one response on out_o with
// the read word, the search index, a status code and the count, empty and full
// flags after the operation. The words live in a single-port-write memory with
// one registered read port, so every entry that an operation touches passes
// through a read state and an execute state in the sequencer. Push, update,
// delete last, error cases and unused codes go from acceptance straight to the
// finished state; pop and peek read one entry; search reads entries until a
// match or the count (at most DEPTH); insert moves m entries up and then writes
// the new word; delete first and delete at move m entries down (m at most
// DEPTH - 1). The input is ready only while the sequencer is idle. The
// response is held in an output register, so the next request is accepted while
// a finished response still waits to be taken; a second response then waits in
// the sequencer until the output register frees up. Entries are not cleared at
// reset and never need to be, since only positions below the count are read.
module bounded_array_stack_list #(
  parameter int unsigned DEPTH = bas_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bas_in_if.sink    in_i,
  bas_out_if.source out_o
);
  import bas_pkg::*;

  // Address, count and comparison widths follow from the depth.
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > PosWidth) ? CW : PosWidth;
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EXE  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        occ_q, occ_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  func_e                func_q, func_d;
  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [DataWidth-1:0] value_q, value_d;
  logic [DataWidth-1:0] rd_q, rd_d;
  logic [IndexWidth-1:0] found_q, found_d;
  status_e              status_q, status_d;

  logic                  out_valid_q, out_valid_d;
  logic [DataWidth-1:0]  out_data_q, out_data_d;
  logic [IndexWidth-1:0] out_found_q, out_found_d;
  logic [StatusWidth-1:0] out_status_q, out_status_d;
  logic [CountWidth-1:0] out_count_q, out_count_d;
  logic                  out_empty_q, out_empty_d;
  logic                  out_full_q, out_full_d;

  // Entry storage: one write and one registered read per cycle.
  logic [DataWidth-1:0] mem [DEPTH];
  logic [DataWidth-1:0] rdata_q;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [DataWidth-1:0] mem_wdata;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;

  func_e                in_func;
  logic [PW-1:0]        in_pos_ext;
  logic [PW-1:0]        pos_q_ext;
  logic [PW-1:0]        occ_ext;
  logic                 is_empty;
  logic                 is_full;
  logic [CW-1:0]        ptr_inc;
  logic [CW-1:0]        ptr_dec;
  logic [CW-1:0]        del_start;
  logic                 out_load;

  assign in_func    = func_e'(in_i.func);
  assign in_pos_ext = PW'(in_i.position);
  assign pos_q_ext  = PW'(pos_q);
  assign occ_ext    = PW'(occ_q);
  assign is_empty   = (occ_q == '0);
  assign is_full    = (occ_q == FullCount);
  assign ptr_inc    = ptr_q + CW'(1);
  assign ptr_dec    = ptr_q - CW'(1);
  assign del_start  = (in_func == FN_DEL_AT) ? CW'(in_i.position) : '0;

  assign in_i.ready = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    ptr_d     = ptr_q;
    func_d    = func_q;
    pos_d     = pos_q;
    value_d   = value_q;
    rd_d      = rd_q;
    found_d   = found_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q[IW-1:0];
    mem_wdata = rdata_q;
    mem_re    = 1'b0;
    mem_raddr = ptr_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          func_d   = in_func;
          pos_d    = in_i.position;
          value_d  = in_i.value;
          rd_d     = '0;
          found_d  = FoundNone;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (in_func) inside
            FN_PUSH: begin
              if (is_full) begin
                status_d = ST_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = occ_q[IW-1:0];
                mem_wdata = in_i.value;
                occ_d     = occ_q + CW'(1);
              end
            end
            FN_POP: begin
              if (is_empty) begin
                status_d = ST_UNDERFLOW;
              end else begin
                occ_d   = occ_q - CW'(1);
                ptr_d   = occ_q - CW'(1);
                state_d = S_RD;
              end
            end
            FN_PEEK: begin
              if (is_empty) begin
                status_d = ST_UNDERFLOW;
              end else if (in_pos_ext >= occ_ext) begin
                status_d = ST_BADPOS;
              end else begin
                ptr_d   = CW'(in_i.position);
                state_d = S_RD;
              end
            end
            FN_UPDATE: begin
              if (in_pos_ext >= occ_ext) begin
                status_d = ST_BADPOS;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IW'(in_i.position);
                mem_wdata = in_i.value;
              end
            end
            FN_SEARCH: begin
              status_d = ST_NOTFOUND;
              if (!is_empty) begin
                ptr_d   = '0;
                state_d = S_RD;
              end
            end
            FN_INSERT: begin
              if (is_full) begin
                status_d = ST_OVERFLOW;
              end else if (in_pos_ext > occ_ext) begin
                status_d = ST_BADPOS;
              end else begin
                ptr_d   = occ_q;
                state_d = (in_pos_ext == occ_ext) ? S_PUT : S_RD;
              end
            end
            FN_DEL_FIRST, FN_DEL_AT: begin
              if (is_empty) begin
                status_d = ST_UNDERFLOW;
              end else if ((in_func == FN_DEL_AT) && (in_pos_ext >= occ_ext)) begin
                status_d = ST_BADPOS;
              end else if ((CW + 1)'(del_start) + (CW + 1)'(1) >= (CW + 1)'(occ_q)) begin
                occ_d = occ_q - CW'(1);
              end else begin
                ptr_d   = del_start;
                state_d = S_RD;
              end
            end
            FN_DEL_LAST: begin
              if (is_empty) begin
                status_d = ST_UNDERFLOW;
              end else begin
                occ_d = occ_q - CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD: begin
        // Insert moves entries up, so it reads below the pointer; deletes
        // move entries down and read above it.
        mem_re = 1'b1;
        case (func_q) inside
          FN_INSERT:               mem_raddr = ptr_dec[IW-1:0];
          FN_DEL_FIRST, FN_DEL_AT: mem_raddr = ptr_inc[IW-1:0];
          default:                 mem_raddr = ptr_q[IW-1:0];
        endcase
        state_d = S_EXE;
      end

      S_EXE: begin
        state_d = S_DONE;
        case (func_q) inside
          FN_POP, FN_PEEK: begin
            rd_d = rdata_q;
          end
          FN_SEARCH: begin
            if (rdata_q == value_q) begin
              found_d  = IndexWidth'(ptr_q);
              status_d = ST_OK;
            end else if (ptr_inc < occ_q) begin
              ptr_d   = ptr_inc;
              state_d = S_RD;
            end
          end
          FN_INSERT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_q[IW-1:0];
            ptr_d     = ptr_dec;
            state_d   = (PW'(ptr_dec) == pos_q_ext) ? S_PUT : S_RD;
          end
          FN_DEL_FIRST, FN_DEL_AT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_q[IW-1:0];
            ptr_d     = ptr_inc;
            if ((CW + 1)'(ptr_q) + (CW + 1)'(2) >= (CW + 1)'(occ_q)) begin
              occ_d = occ_q - CW'(1);
            end else begin
              state_d = S_RD;
            end
          end
          default: begin
          end
        endcase
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(pos_q);
        mem_wdata = value_q;
        occ_d     = occ_q + CW'(1);
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loads a finished response, clears once it is taken.
  always_comb begin
    out_valid_d  = out_valid_q && !out_o.ready;
    out_data_d   = out_data_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_data_d   = rd_q;
      out_found_d  = found_q;
      out_status_d = status_q;
      out_count_d  = CountWidth'(occ_q);
      out_empty_d  = is_empty;
      out_full_d   = is_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    func_q       <= func_d;
    pos_q        <= pos_d;
    value_q      <= value_d;
    rd_q         <= rd_d;
    found_q      <= found_d;
    status_q     <= status_d;
    out_data_q   <= out_data_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
    out_full_q   <= out_full_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = out_data_q;
  assign out_o.found_index = out_found_q;
  assign out_o.status      = out_status_q;
  assign out_o.fill_count  = out_count_q;
  assign out_o.is_empty    = out_empty_q;
  assign out_o.is_full     = out_full_q;

`ifndef NO_ASSERTIONS
  // The count never exceeds the capacity.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FullCount)
    else $error("stack count exceeds capacity");

  // An accepted request always starts the sequencer.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted request left the sequencer idle");

  // The count moves by at most one entry per cycle.
  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + CW'(1))
      || (occ_q == $past(occ_q) - CW'(1)))
    else $error("stack count jumped by more than one");

  // In the read state the walk pointer never exceeds the count.
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (ptr_q <= occ_q))
    else $error("walk pointer beyond stack count");
`endif

endmodule

/* test/bas_stack_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the stack, predicts one response per accepted request
// and compares each taken response, in order, with the oldest prediction.
module bas_stack_checker #(
  parameter int unsigned DEPTH = bas_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bas_in_if           req_mon,
  bas_out_if          rsp_mon,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import bas_pkg::*;

  typedef struct packed {
    logic signed [DataWidth-1:0]  read_data;
    logic signed [IndexWidth-1:0] found_index;
    status_e                      status;
    logic [CountWidth-1:0]        fill_count;
    logic                         is_empty;
    logic                         is_full;
  } stack_rsp_t;

  logic signed [DataWidth-1:0] words [DEPTH];
  int unsigned                 held = 0;
  stack_rsp_t                  expected_rsps [$];
  int unsigned                 mismatches = 0;
  int unsigned                 checked = 0;

  // Applies one request to the shadow stack and returns the response it must give.
  function automatic stack_rsp_t predict_stack(input logic [FuncWidth-1:0] fn,
                                               input logic [PosWidth-1:0] pos,
                                               input logic signed [DataWidth-1:0] val);
    stack_rsp_t  r;
    int unsigned p;
    int unsigned i;
    r.read_data   = '0;
    r.found_index = FoundNone;
    r.status      = ST_OK;
    p = pos;
    case (fn)
      FN_PUSH: begin
        if (held >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          words[held] = val;
          held++;
        end
      end
      FN_POP: begin
        if (held == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          held--;
          r.read_data = words[held];
        end
      end
      FN_PEEK: begin
        if (held == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (p >= held) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_data = words[p];
        end
      end
      FN_UPDATE: begin
        if (p >= held) begin
          r.status = ST_BADPOS;
        end else begin
          words[p] = val;
        end
      end
      FN_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < held; i++) begin
          if (words[i] == val) begin
            r.found_index = IndexWidth'(i);
            r.status      = ST_OK;
            break;
          end
        end
      end
      FN_INSERT: begin
        if (held >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (p > held) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = held; i > p; i--) words[i] = words[i-1];
          words[p] = val;
          held++;
        end
      end
      FN_DEL_FIRST: begin
        if (held == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          for (i = 0; i + 1 < held; i++) words[i] = words[i+1];
          held--;
        end
      end
      FN_DEL_LAST: begin
        if (held == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          held--;
        end
      end
      FN_DEL_AT: begin
        if (held == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (p >= held) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p; i + 1 < held; i++) words[i] = words[i+1];
          held--;
        end
      end
      default: begin
      end
    endcase
    r.fill_count = CountWidth'(held);
    r.is_empty   = (held == 0);
    r.is_full    = (held >= DEPTH);
    return r;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    stack_rsp_t want;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) begin
        expected_rsps.push_back(predict_stack(req_mon.func, req_mon.position,
                                              req_mon.value));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response taken while no request was outstanding");
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          checked++;
          if (rsp_mon.read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, rsp_mon.read_data);
            mismatches++;
          end
          if (rsp_mon.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index,
                   rsp_mon.found_index);
            mismatches++;
          end
          if (rsp_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
            mismatches++;
          end
          if (rsp_mon.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count,
                   rsp_mon.fill_count);
            mismatches++;
          end
          if (rsp_mon.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, rsp_mon.is_empty);
            mismatches++;
          end
          if (rsp_mon.is_full !== want.is_full) begin
            $error("is_full: expected %0b, got %0b", want.is_full, rsp_mon.is_full);
            mismatches++;
          end
        end
      end
      errors_o  <= mismatches;
      pending_o <= expected_rsps.size();
      checked_o <= checked;
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

// Top of the stack testbench. It owns the clock, the reset, the request sender
// and the response taker; all prediction and comparison live in the checker
// instantiated beside the block. The top only decides what to send, when each
// side pauses, and what verdict to print.
module tb;
  import bas_pkg::*;

  localparam int unsigned Depth         = DefaultDepth;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned IdlePercent   = 33;
  // The longest request is a search over a full stack.
  localparam int unsigned DrainCycles   = 2 * Depth + 8;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned PhaseCount    = 16;
  localparam int unsigned PhaseItems    = 60;
  localparam int unsigned CycleLimit    = 300000;
  // Function codes past the last named operation are accepted and do nothing.
  localparam int unsigned FnFirstUnused = int'(FN_DEL_AT) + 1;
  localparam int unsigned FnLastCode    = (1 << FuncWidth) - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bas_in_if  req_ch ();
  bas_out_if rsp_ch ();

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;

  // When set, neither side pauses; this gives a stretch of back-to-back traffic.
  bit          steady = 1'b0;
  // Each increment asks the response taker for one long hold-off.
  int unsigned hold_offs_asked = 0;
  int unsigned sent_count = 0;
  int unsigned directed_count = 0;

  always #6 clk_i = ~clk_i;

  bounded_array_stack_list #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (rsp_ch)
  );

  bas_stack_checker #(
    .DEPTH(Depth)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_mon  (req_ch),
    .rsp_mon  (rsp_ch),
    .errors_o (errors),
    .pending_o(pending),
    .checked_o(checked)
  );

  // Decides whether a side sits out the current cycle.
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < IdlePercent);
  endfunction

  // Drives one request starting at a falling edge and returns at the falling edge
  // after it was accepted. The valid line gets a single assignment per edge, so a
  // request that follows directly keeps valid high without a glitch.
  task automatic send_req(input logic [FuncWidth-1:0] fn, input logic [PosWidth-1:0] pos,
                          input logic signed [DataWidth-1:0] val);
    while (take_break()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= fn;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Picks an operation. A growing phase leans on push and insert so the stack
  // reaches full; a shrinking phase leans on the deletes so it drains to empty.
  // A few percent of requests carry an unused code.
  function automatic logic [FuncWidth-1:0] pick_func(input bit growing);
    int unsigned roll;
    if ($urandom_range(99) < 3) begin
      return FuncWidth'($urandom_range(FnLastCode, FnFirstUnused));
    end
    roll = $urandom_range(99);
    if (growing) begin
      if (roll < 40) return FN_PUSH;
      if (roll < 55) return FN_INSERT;
    end else begin
      if (roll < 10) return FN_PUSH;
      if (roll < 16) return FN_INSERT;
      if (roll < 60) begin
        case ($urandom_range(3))
          0:       return FN_POP;
          1:       return FN_DEL_FIRST;
          2:       return FN_DEL_LAST;
          default: return FN_DEL_AT;
        endcase
      end
    end
    case ($urandom_range(6))
      0:       return FN_POP;
      1:       return FN_DEL_FIRST;
      2:       return FN_DEL_LAST;
      3:       return FN_DEL_AT;
      4:       return FN_PEEK;
      5:       return FN_UPDATE;
      default: return FN_SEARCH;
    endcase
  endfunction

  // Words are drawn often from a handful of small values so that searches hit,
  // duplicates show which index wins, and updates overwrite with equal words.
  function automatic logic signed [DataWidth-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return DataWidth'($urandom_range(7));
    if (roll < 50) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return '1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // Response taker. It normally pauses at random; when a hold-off is asked for it
  // keeps ready low for a counted stretch, which lets the output register and the
  // sequencer fill so that the block has to stall its request side.
  initial begin : rsp_taker
    int unsigned served;
    served = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && hold_offs_asked > served) begin
        served++;
        rsp_ch.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else begin
        rsp_ch.ready <= rst_ni && !take_break();
      end
    end
  end

  // The run ends here if it has not finished within the cycle limit.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    req_ch.valid    = 1'b0;
    req_ch.func     = FN_PUSH;
    req_ch.position = '0;
    req_ch.value    = '0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Every operation but push is tried on an empty stack first: the
    // removals and peek must underflow, update and an insert past the end must
    // report a bad position, and a search must come back not found.
    send_req(FN_POP, 0, 0);
    send_req(FN_PEEK, 0, 0);
    send_req(FN_UPDATE, 0, 32'h1234_5678);
    send_req(FN_DEL_FIRST, 0, 0);
    send_req(FN_DEL_LAST, 0, 0);
    send_req(FN_DEL_AT, 0, 0);
    send_req(FN_SEARCH, 0, 0);
    send_req(FN_INSERT, 1, 7);
    // Insert at the current count appends, here into an empty stack.
    send_req(FN_INSERT, 0, 32'h8000_0000);
    send_req(FN_PUSH, 0, 32'h7FFF_FFFF);
    send_req(FN_PUSH, 0, '1);
    // Peek past the top is a bad position; the highest named position is used.
    send_req(FN_PEEK, '1, 0);
    send_req(FN_PEEK, 2, 0);
    send_req(FN_UPDATE, 1, 0);
    send_req(FN_SEARCH, 0, 0);
    // The highest unused code must leave everything alone.
    send_req(FuncWidth'(FnLastCode), '1, '1);
    send_req(FN_INSERT, 3, 5);
    send_req(FN_INSERT, 0, 32'h5555_5555);
    send_req(FN_PUSH, 0, 32'hAAAA_AAAA);
    send_req(FN_PUSH, 0, 0);
    send_req(FN_PUSH, 0, 1);
    // The stack is now full: push and insert must overflow without change.
    send_req(FN_PUSH, 0, 9);
    send_req(FN_INSERT, 0, 9);
    send_req(FN_DEL_AT, '1, 0);
    send_req(FN_DEL_FIRST, 0, 0);
    send_req(FN_POP, 0, 0);
    directed_count = sent_count;

    // Random part: phases alternate between growing and shrinking the stack.
    // One phase runs with no pauses on either side, and two phases start with a
    // long hold-off on the response side while requests keep coming.
    for (phase = 0; phase < PhaseCount; phase++) begin
      steady = (phase == 3);
      if (phase == 5 || phase == 10) hold_offs_asked++;
      for (n = 0; n < PhaseItems; n++) begin
        send_req(pick_func(phase % 2 == 0), PosWidth'($urandom_range(7)), pick_word());
      end
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;

    // Wait for every prediction to be matched, then a little longer so that any
    // spurious extra response would still be seen by the checker.
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("tb: %0d requests sent (%0d directed, rest random), %0d responses compared",
             sent_count, directed_count, checked);
    $display("tb: covered all operations, unused codes, empty and full stacks, %0d hold-offs",
             hold_offs_asked);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
